/* sv/psc_pkg.sv */
// Package for the pressure sensor compensation unit.
// Holds the microcode word type, the control program, register indexes and constants.
// No dependencies.
package psc_pkg;

	localparam int  RawW   = 24;
	localparam int  CalW   = 16;
	localparam int  OperW  = 26;
	localparam int  ProdW  = 2 * OperW;
	localparam int  StepW  = 4;

	localparam longint TEMP_BASE = 2000;
	localparam longint TEMP_LOW  = -4000;
	localparam longint TEMP_HIGH = 8500;
	localparam longint PRES_LOW  = 1000;
	localparam longint PRES_HIGH = 120000;

	typedef enum logic [2:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		A_DT,
		A_DD,
		A_D1
	} a_sel_t;

	typedef enum logic [2:0] {
		B_C6,
		B_C4,
		B_C3,
		B_DT,
		B_DD,
		B_SLO,
		B_SHI
	} b_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DT,
		OP_TEMP,
		OP_OFF,
		OP_SENS,
		OP_TI,
		OP_OFFI,
		OP_SENSI,
		OP_LOAD,
		OP_ACCHI,
		OP_SHR21,
		OP_SUBOFF,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_WARM,
		J_END
	} jump_t;

	typedef logic [StepW-1:0] step_t;

	typedef struct packed {
		logic   mul_en;
		a_sel_t a_sel;
		b_sel_t b_sel;
		op_t    op;
		jump_t  jump;
		step_t  target;
	} uword_t;

	localparam step_t STEP_PRESS  = 4'd8;
	localparam step_t STEP_FINISH = 4'd13;

	// control program
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{1'b0, A_DT, B_C6, OP_NOP, J_NEXT, '0};
		unique case (step)
			4'd0:  w = '{1'b0, A_DT, B_C6,  OP_DT,     J_NEXT, '0};
			4'd1:  w = '{1'b1, A_DT, B_C6,  OP_NOP,    J_NEXT, '0};
			4'd2:  w = '{1'b1, A_DT, B_C4,  OP_TEMP,   J_NEXT, '0};
			4'd3:  w = '{1'b1, A_DT, B_C3,  OP_OFF,    J_NEXT, '0};
			4'd4:  w = '{1'b1, A_DT, B_DT,  OP_SENS,   J_WARM, STEP_PRESS};
			4'd5:  w = '{1'b1, A_DD, B_DD,  OP_TI,     J_NEXT, '0};
			4'd6:  w = '{1'b0, A_DT, B_C6,  OP_OFFI,   J_NEXT, '0};
			4'd7:  w = '{1'b0, A_DT, B_C6,  OP_SENSI,  J_NEXT, '0};
			4'd8:  w = '{1'b1, A_D1, B_SLO, OP_NOP,    J_NEXT, '0};
			4'd9:  w = '{1'b1, A_D1, B_SHI, OP_LOAD,   J_NEXT, '0};
			4'd10: w = '{1'b0, A_DT, B_C6,  OP_ACCHI,  J_NEXT, '0};
			4'd11: w = '{1'b0, A_DT, B_C6,  OP_SHR21,  J_NEXT, '0};
			4'd12: w = '{1'b0, A_DT, B_C6,  OP_SUBOFF, J_NEXT, '0};
			4'd13: w = '{1'b0, A_DT, B_C6,  OP_FINISH, J_END,  '0};
			default: w = '{1'b0, A_DT, B_C6, OP_NOP, J_END, '0};
		endcase
		return w;
	endfunction

	// signed divide by 2^k, truncating toward zero
	function automatic logic signed [63:0] div_pow2(input logic signed [63:0] x,
		input logic [5:0] k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

/* sv/pressure_sensor_compensation_unit.sv */
// Top level of the pressure sensor compensation unit.
// Microcoded datapath around one shared 26x26 signed multiplier; uses psc_pkg.
// Calibration words are written through the plain configuration port.

// Each beat on the input carries one raw pressure and one raw temperature
// conversion; the unit answers with exactly one beat holding the held
// temperature (0.01 degC) and held pressure (0.01 mbar) plus two update flags.
// The control program steps one microcode word per cycle through a single
// shared multiplier, stalling at its finish step while the output register
// still holds an untaken beat; at or above 20.00 degC it skips the low-temperature
// correction steps. The next input beat is taken the cycle after the result is loaded into the output register.
// Calibration words may be written only while the unit is idle.
module pressure_sensor_compensation_unit
	import psc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // temperature_hundredths[14:0], pressure_hundredths[31:15]
	output logic [1:0]  m_tuser,   // temperature_updated[0], pressure_updated[1]
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic [RawW-1:0] d1_q, d2_q;
	logic signed [24:0] dt_q;
	logic signed [19:0] temp_q;
	logic signed [39:0] off_q;
	logic signed [37:0] sens_q;
	logic signed [ProdW-1:0] prod_q;
	logic signed [63:0] acc_q;
	logic        busy_q;
	step_t       step_q;
	logic        out_valid_q;
	logic        t_upd_q, p_upd_q;
	logic signed [14:0] held_t_q;
	logic [16:0] held_p_q;

	uword_t uw;
	logic signed [OperW-1:0] mul_a, mul_b;
	logic signed [ProdW-1:0] mul_res;
	logic signed [20:0] dd;
	logic signed [63:0] p64, temp64, off64, sens64, res, pres;
	logic        out_free, fin_go, advance, warm, t_ok, p_ok;

	assign uw       = ucode(step_q);
	assign s_tready = !busy_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {held_p_q, held_t_q};
	assign m_tuser  = {p_upd_q, t_upd_q};

	assign out_free = !out_valid_q || m_tready;
	assign fin_go   = busy_q && (uw.op == OP_FINISH) && out_free;
	assign advance  = busy_q && ((uw.op != OP_FINISH) || out_free);
	assign warm     = temp_q >= 20'sd2000;

	assign dd     = {temp_q[19], temp_q} - 21'sd2000;
	assign p64    = {{(64-ProdW){prod_q[ProdW-1]}}, prod_q};
	assign temp64 = {{44{temp_q[19]}}, temp_q};
	assign off64  = {{24{off_q[39]}}, off_q};
	assign sens64 = {{26{sens_q[37]}}, sens_q};

	always_comb begin
		case (uw.a_sel)
			A_DT:    mul_a = {dt_q[24], dt_q};
			A_DD:    mul_a = {{5{dd[20]}}, dd};
			A_D1:    mul_a = {2'b00, d1_q};
			default: mul_a = '0;
		endcase
		case (uw.b_sel)
			B_C6:    mul_b = {10'd0, c6_q};
			B_C4:    mul_b = {10'd0, c4_q};
			B_C3:    mul_b = {10'd0, c3_q};
			B_DT:    mul_b = {dt_q[24], dt_q};
			B_DD:    mul_b = {{5{dd[20]}}, dd};
			B_SLO:   mul_b = {7'd0, sens_q[18:0]};
			B_SHI:   mul_b = {{7{sens_q[37]}}, sens_q[37:19]};
			default: mul_b = '0;
		endcase
	end

	assign mul_res = mul_a * mul_b;

	always_comb begin
		res = '0;
		unique case (uw.op)
			OP_DT:     res = $signed({40'd0, d2_q}) - $signed({32'd0, c5_q, 8'd0});
			OP_TEMP:   res = TEMP_BASE + div_pow2(p64, 6'd23);
			OP_OFF:    res = $signed({31'd0, c2_q, 17'd0}) + div_pow2(p64, 6'd6);
			OP_SENS:   res = $signed({32'd0, c1_q, 16'd0}) + div_pow2(p64, 6'd7);
			OP_TI:     res = temp64 - (((p64 <<< 3) + (p64 <<< 1) + p64) >>> 35);
			OP_OFFI:   res = off64 - (((p64 <<< 5) - p64) >>> 3);
			OP_SENSI:  res = sens64 - (((p64 <<< 6) - p64) >>> 5);
			OP_LOAD:   res = p64;
			OP_ACCHI:  res = acc_q + (p64 <<< 19);
			OP_SHR21:  res = div_pow2(acc_q, 6'd21);
			OP_SUBOFF: res = acc_q - off64;
			OP_FINISH: res = acc_q;
			OP_NOP:    res = '0;
			default:   res = '0;
		endcase
	end

	assign pres = div_pow2(acc_q, 6'd15);
	assign t_ok = (temp64 >= TEMP_LOW) && (temp64 <= TEMP_HIGH);
	assign p_ok = (pres >= PRES_LOW) && (pres <= PRES_HIGH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_C1:  c1_q <= cfg_data;
				REG_C2:  c2_q <= cfg_data;
				REG_C3:  c3_q <= cfg_data;
				REG_C4:  c4_q <= cfg_data;
				REG_C5:  c5_q <= cfg_data;
				REG_C6:  c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			t_upd_q     <= 1'b0;
			p_upd_q     <= 1'b0;
			held_t_q    <= '0;
			held_p_q    <= '0;
		end else begin
			if (s_tvalid && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (advance) begin
				unique case (uw.jump)
					J_NEXT: step_q <= step_q + 4'd1;
					J_WARM: step_q <= warm ? uw.target : step_q + 4'd1;
					J_END:  busy_q <= 1'b0;
					default: busy_q <= 1'b0;
				endcase
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				t_upd_q     <= t_ok;
				p_upd_q     <= p_ok;
				if (t_ok) begin
					held_t_q <= temp_q[14:0];
				end
				if (p_ok) begin
					held_p_q <= pres[16:0];
				end
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && !busy_q) begin
			d1_q <= s_tdata[23:0];
			d2_q <= s_tdata[47:24];
		end
		if (busy_q && uw.mul_en) begin
			prod_q <= mul_res;
		end
		if (busy_q) begin
			case (uw.op)
				OP_DT:                     dt_q   <= res[24:0];
				OP_TEMP, OP_TI:            temp_q <= res[19:0];
				OP_OFF, OP_OFFI:           off_q  <= res[39:0];
				OP_SENS, OP_SENSI:         sens_q <= res[37:0];
				OP_LOAD, OP_ACCHI, OP_SHR21, OP_SUBOFF: acc_q <= res;
				default: ;
			endcase
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_FINISH)
		else $error("step counter ran past the program");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> !busy_q && m_tvalid)
		else $error("finish step did not release the sequencer");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			$signed(m_tdata[14:0]) >= -15'sd4000 && $signed(m_tdata[14:0]) <= 15'sd8500)
		else $error("updated temperature out of range");

	a_pres_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[31:15] >= 17'd1000 && m_tdata[31:15] <= 17'd120000)
		else $error("updated pressure out of range");

endmodule
